>>> rtl/thermistor_beta_temperature_assert.svh
// Assertion macros for the thermistor temperature RTL.
`ifndef THERMISTOR_BETA_TEMPERATURE_ASSERT_SVH
`define THERMISTOR_BETA_TEMPERATURE_ASSERT_SVH

// Same-cycle implication, sampled on clk and idle during reset.
`define TBT_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("tbt assertion failed");

// Next-cycle implication, sampled on clk and idle during reset.
`define TBT_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("tbt assertion failed");

`endif

>>> rtl/tbt_pkg.sv
// Shared constants and types for the thermistor temperature pipeline.
package tbt_pkg;
	localparam int LOG_FB   = 24;
	localparam int EXP_W    = 6;
	localparam int LOG_W    = EXP_W + LOG_FB;
	localparam int MANT_W   = 32;
	localparam int LOG_LAT  = LOG_FB + 1;
	localparam int FS_W     = 12;
	localparam int SER_W    = 20;
	localparam int R0_W     = 24;
	localparam int BETA_W   = 16;
	localparam int T0_W     = 16;
	localparam int CFG_W    = 24;
	localparam int CFG_IDX_W = 3;
	localparam int TEMP_W   = 19;
	localparam int QUO_W    = 19;
	localparam logic [29:0] LN2_Q30 = 30'd744261118;
	localparam logic [TEMP_W-1:0] ZERO_C_CK = 19'd27315;
	localparam logic [TEMP_W-1:0] OUT_MAX   = 19'd262143;
	localparam logic [TEMP_W-1:0] TCK_MAX   = 19'd289458;
	localparam logic [TEMP_W-1:0] TEMP_FLOOR = 19'd496973;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SERIES,
		CFG_NOMINAL_R,
		CFG_BETA,
		CFG_NOMINAL_T,
		CFG_FULL_SCALE
	} cfg_idx_t;
endpackage

>>> rtl/thermistor_beta_temperature.sv
// Throughput: one sample per cycle while the skid register is empty; the two
// 25-stage log lanes and the 20-stage restoring divider each take a new operand
// every cycle in which ce is high.
// A stalled output parks one word in a skid register, then the pipeline holds.
// Reset (arst_n low, asynchronous) empties the pipeline and loads the default
// register set: 10000 ohm, 100000 ohm, beta 4390, 298.15 K, full scale 4095.
module thermistor_beta_temperature #(
	parameter int ADC_BITS = 12
) (
	input  logic clk,
	input  logic arst_n,
	// s_axis_tdata: adc_sample
	input  logic                         s_axis_tvalid,
	output logic                         s_axis_tready,
	input  logic [((ADC_BITS+7)/8)*8-1:0] s_axis_tdata,
	// m_axis_tdata: temp_centi_celsius
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,
	// m_axis_tuser: out_of_range
	output logic        m_axis_tuser,
	input  logic                             cfg_wr_en,
	input  logic [tbt_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [tbt_pkg::CFG_W-1:0]        cfg_wdata
);
	localparam int FS_W  = tbt_pkg::FS_W;
	localparam int CMP_W = (ADC_BITS > FS_W) ? ADC_BITS : FS_W;
	localparam int N_W   = tbt_pkg::SER_W + FS_W;
	localparam int D_W   = tbt_pkg::R0_W + FS_W + 1;
	localparam int LW    = tbt_pkg::LOG_W;
	localparam int LL    = tbt_pkg::LOG_LAT;
	localparam int QW    = tbt_pkg::QUO_W;
	localparam int TW    = tbt_pkg::TEMP_W;

	typedef struct packed {
		logic zero;
		logic dneg;
		logic dzero;
		logic big;
	} flags_t;

	// Configuration registers.
	logic [tbt_pkg::SER_W-1:0]  series_q;
	logic [tbt_pkg::R0_W-1:0]   r0_q;
	logic [tbt_pkg::BETA_W-1:0] beta_q;
	logic [tbt_pkg::T0_W-1:0]   t0_q;
	logic [FS_W-1:0]            fs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			series_q <= 20'd10000;
			r0_q     <= 24'd100000;
			beta_q   <= 16'd4390;
			t0_q     <= 16'd29815;
			fs_q     <= 12'd4095;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				tbt_pkg::CFG_SERIES:     series_q <= cfg_wdata[tbt_pkg::SER_W-1:0];
				tbt_pkg::CFG_NOMINAL_R:  r0_q     <= cfg_wdata[tbt_pkg::R0_W-1:0];
				tbt_pkg::CFG_BETA:       beta_q   <= cfg_wdata[tbt_pkg::BETA_W-1:0];
				tbt_pkg::CFG_NOMINAL_T:  t0_q     <= cfg_wdata[tbt_pkg::T0_W-1:0];
				tbt_pkg::CFG_FULL_SCALE: fs_q     <= cfg_wdata[FS_W-1:0];
				default: ;
			endcase
		end
	end

	logic [tbt_pkg::R0_W-1:0]   r0_eff;
	logic [tbt_pkg::BETA_W-1:0] beta_eff;
	logic [tbt_pkg::T0_W-1:0]   t0_eff;
	assign r0_eff   = (r0_q == '0) ? tbt_pkg::R0_W'(1) : r0_q;
	assign beta_eff = (beta_q == '0) ? tbt_pkg::BETA_W'(1) : beta_q;
	assign t0_eff   = (t0_q == '0) ? tbt_pkg::T0_W'(1) : t0_q;

	// Constants derived from the registers; they settle long before a sample
	// reaches the stages that use them.
	logic [31:0] tb_q;
	logic [38:0] numc_q;
	logic [22:0] pref_q;
	always_ff @(posedge clk) begin
		tb_q   <= 32'(t0_eff) * 32'(beta_eff);
		numc_q <= 39'(tb_q) * 39'd100;
		pref_q <= 23'(23'(beta_eff) * 23'd100);
	end

	logic ce;
	logic skid_vld_q;
	assign ce = !skid_vld_q;
	assign s_axis_tready = ce;

	// Stage 1: clamp and divider leg.
	logic [CMP_W-1:0] samp_ext, fs_ext;
	logic [FS_W-1:0]  samp_cl;
	assign samp_ext = CMP_W'(s_axis_tdata[ADC_BITS-1:0]);
	assign fs_ext   = CMP_W'(fs_q);
	assign samp_cl  = (samp_ext > fs_ext) ? fs_q : samp_ext[FS_W-1:0];

	logic            vld_s1, zero_s1;
	logic [FS_W-1:0] samp_s1;
	logic [FS_W:0]   dm_s1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (ce) begin
			vld_s1 <= s_axis_tvalid;
		end
	end
	always_ff @(posedge clk) begin
		if (ce) begin
			samp_s1 <= samp_cl;
			dm_s1   <= (FS_W+1)'(fs_q) - (FS_W+1)'(samp_cl) + (FS_W+1)'(1);
			zero_s1 <= (samp_cl == '0) || (series_q == '0);
		end
	end

	// Stage 2: both resistance terms.
	logic           vld_s2, zero_s2;
	logic [N_W-1:0] n_s2;
	logic [D_W-1:0] d_s2;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (ce) begin
			vld_s2 <= vld_s1;
		end
	end
	always_ff @(posedge clk) begin
		if (ce) begin
			n_s2    <= N_W'(series_q) * N_W'(samp_s1);
			d_s2    <= D_W'(r0_eff) * D_W'(dm_s1);
			zero_s2 <= zero_s1;
		end
	end

	// Log lanes with valid and zero flags riding alongside.
	logic [LW-1:0] ln_n, ln_d;
	tbt_log2 #(.IN_W(N_W)) u_log_n (.clk(clk), .ce(ce), .val(n_s2), .log_val(ln_n));
	tbt_log2 #(.IN_W(D_W)) u_log_d (.clk(clk), .ce(ce), .val(d_s2), .log_val(ln_d));

	logic vld_lg  [0:LL-1];
	logic zero_lg [0:LL-1];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < LL; i++) begin
				vld_lg[i] <= 1'b0;
			end
		end else if (ce) begin
			vld_lg[0] <= vld_s2;
			for (int i = 1; i < LL; i++) begin
				vld_lg[i] <= vld_lg[i-1];
			end
		end
	end
	always_ff @(posedge clk) begin
		if (ce) begin
			zero_lg[0] <= zero_s2;
			for (int i = 1; i < LL; i++) begin
				zero_lg[i] <= zero_lg[i-1];
			end
		end
	end

	// Stages 3 to 7: log difference, scale by ln 2, form den and the dividend.
	logic          vld_s3, vld_s4, vld_s5, vld_s6, vld_s7;
	logic          zero_s3, zero_s4, zero_s5, zero_s6, zero_s7;
	logic          neg_s3, neg_s4, neg_s5;
	logic [LW-1:0] mag_s3;
	logic [29:0]   lnmag_s4;
	logic [45:0]   p_s5;
	logic [48:0]   den_s6;
	logic [63:0]   num_s7;
	logic [47:0]   den_s7;
	logic          dneg_s7, dzero_s7;
	logic [60:0]   lnprod;
	logic [48:0]   pref_ext;

	assign lnprod   = 61'(mag_s3) * 61'(tbt_pkg::LN2_Q30) + 61'(1) * (61'(1) << 29);
	assign pref_ext = {2'b00, pref_q, 24'b0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
		end else if (ce) begin
			vld_s3 <= vld_lg[LL-1];
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
		end
	end
	always_ff @(posedge clk) begin
		if (ce) begin
			zero_s3  <= zero_lg[LL-1];
			neg_s3   <= ln_n < ln_d;
			mag_s3   <= (ln_n < ln_d) ? (ln_d - ln_n) : (ln_n - ln_d);
			zero_s4  <= zero_s3;
			neg_s4   <= neg_s3;
			lnmag_s4 <= lnprod[59:30];
			zero_s5  <= zero_s4;
			neg_s5   <= neg_s4;
			p_s5     <= 46'(lnmag_s4) * 46'(t0_eff);
			zero_s6  <= zero_s5;
			den_s6   <= neg_s5 ? (pref_ext - 49'(p_s5)) : (pref_ext + 49'(p_s5));
			zero_s7  <= zero_s6;
			dneg_s7  <= den_s6[48];
			dzero_s7 <= den_s6 == '0;
			den_s7   <= den_s6[47:0];
			num_s7   <= 64'({numc_q, 24'b0}) + 64'(den_s6[47:1]);
		end
	end

	// Divider: stage 0 checks for a quotient of 2^19 or more, then one
	// restoring step per stage from the top quotient bit down.
	logic          vld_dv  [0:QW];
	flags_t        flg_dv  [0:QW];
	logic [63:0]   rem_dv  [0:QW];
	logic [47:0]   den_dv  [0:QW];
	logic [QW-1:0] quo_dv  [0:QW];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i <= QW; i++) begin
				vld_dv[i] <= 1'b0;
			end
		end else if (ce) begin
			vld_dv[0] <= vld_s7;
			for (int i = 1; i <= QW; i++) begin
				vld_dv[i] <= vld_dv[i-1];
			end
		end
	end
	always_ff @(posedge clk) begin
		if (ce) begin
			flg_dv[0].zero  <= zero_s7;
			flg_dv[0].dneg  <= dneg_s7;
			flg_dv[0].dzero <= dzero_s7;
			flg_dv[0].big   <= {3'b000, num_s7} >= {den_s7, {QW{1'b0}}};
			rem_dv[0]       <= num_s7;
			den_dv[0]       <= den_s7;
			quo_dv[0]       <= '0;
		end
	end

	for (genvar j = 0; j < QW; j++) begin : g_div
		logic [66:0] rem_ext, trial;
		logic        take;
		assign rem_ext = {3'b000, rem_dv[j]};
		assign trial   = 67'(den_dv[j]) << (QW - 1 - j);
		assign take    = rem_ext >= trial;
		always_ff @(posedge clk) begin
			if (ce) begin
				flg_dv[j+1] <= flg_dv[j];
				den_dv[j+1] <= den_dv[j];
				rem_dv[j+1] <= take ? 64'(rem_ext - trial) : rem_dv[j];
				quo_dv[j+1] <= {quo_dv[j][QW-2:0], take};
			end
		end
	end

	// Final stage: special cases and saturation.
	flags_t        flg_end;
	logic [QW-1:0] tck;
	logic          fin_vld_q;
	logic [TW-1:0] fin_temp_q;
	logic          fin_oor_q;
	assign flg_end = flg_dv[QW];
	assign tck     = quo_dv[QW];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fin_vld_q <= 1'b0;
		end else if (ce) begin
			fin_vld_q <= vld_dv[QW];
		end
	end
	always_ff @(posedge clk) begin
		if (ce) begin
			if (flg_end.zero || (!flg_end.dzero && flg_end.dneg)) begin
				fin_temp_q <= -tbt_pkg::ZERO_C_CK;
				fin_oor_q  <= 1'b1;
			end else if (flg_end.dzero || flg_end.big || (tck > tbt_pkg::TCK_MAX)) begin
				fin_temp_q <= tbt_pkg::OUT_MAX;
				fin_oor_q  <= 1'b1;
			end else begin
				fin_temp_q <= tck - tbt_pkg::ZERO_C_CK;
				fin_oor_q  <= 1'b0;
			end
		end
	end

	// Output register with a one-word skid behind it.
	logic [TW-1:0] out_temp_q, skid_temp_q;
	logic          out_oor_q, skid_oor_q, out_vld_q;
	logic          arrive;
	assign arrive = ce && fin_vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (out_vld_q && !m_axis_tready) begin
			if (arrive) begin
				skid_vld_q <= 1'b1;
			end
		end else if (skid_vld_q) begin
			out_vld_q  <= 1'b1;
			skid_vld_q <= 1'b0;
		end else begin
			out_vld_q <= arrive;
		end
	end
	always_ff @(posedge clk) begin
		if (out_vld_q && !m_axis_tready) begin
			if (arrive) begin
				skid_temp_q <= fin_temp_q;
				skid_oor_q  <= fin_oor_q;
			end
		end else if (skid_vld_q) begin
			out_temp_q <= skid_temp_q;
			out_oor_q  <= skid_oor_q;
		end else begin
			out_temp_q <= fin_temp_q;
			out_oor_q  <= fin_oor_q;
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = {{(24-TW){1'b0}}, out_temp_q};
	assign m_axis_tuser  = out_oor_q;

`include "thermistor_beta_temperature_assert.svh"

	// A parked word always has an occupied output register ahead of it.
	`TBT_ASSERT_IMPL(a_skid_behind_out, skid_vld_q, out_vld_q)
	// The parked word stays while the consumer keeps stalling.
	`TBT_ASSERT_NEXT(a_skid_holds, skid_vld_q && !m_axis_tready, skid_vld_q)
	// An in-range result never lies below absolute zero.
	`TBT_ASSERT_IMPL(a_temp_floor, out_vld_q && !out_oor_q,
		!out_temp_q[TW-1] || (out_temp_q >= tbt_pkg::TEMP_FLOOR))
endmodule

>>> rtl/tbt_log2.sv
// Pipelined base-2 logarithm: leading-one normalize, then one squaring step per stage.
module tbt_log2 #(
	parameter int IN_W = 32
) (
	input  logic                     clk,
	input  logic                     ce,
	input  logic [IN_W-1:0]          val,
	output logic [tbt_pkg::LOG_W-1:0] log_val
);
	localparam int FB = tbt_pkg::LOG_FB;
	localparam int MW = tbt_pkg::MANT_W;

	logic [tbt_pkg::EXP_W-1:0] exp_c;
	logic [IN_W+MW-2:0]        norm_c;
	logic [MW-1:0]             mant_s [0:FB];
	logic [FB-1:0]             frac_s [0:FB];
	logic [tbt_pkg::EXP_W-1:0] exp_s  [0:FB];

	always_comb begin
		exp_c = '0;
		for (int b = 0; b < IN_W; b++) begin
			if (val[b]) begin
				exp_c = tbt_pkg::EXP_W'(b);
			end
		end
		// Shifting left by MW-1 and then right by the exponent covers both
		// the widening and the narrowing case of the mantissa alignment.
		norm_c = {val, {(MW-1){1'b0}}} >> exp_c;
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			mant_s[0] <= norm_c[MW-1:0];
			frac_s[0] <= '0;
			exp_s[0]  <= exp_c;
		end
	end

	for (genvar i = 0; i < FB; i++) begin : g_sq
		logic [2*MW-1:0] sq;
		logic [MW:0]     sh;
		assign sq = (2*MW)'(mant_s[i]) * (2*MW)'(mant_s[i]);
		assign sh = sq[2*MW-1:MW-1];
		always_ff @(posedge clk) begin
			if (ce) begin
				mant_s[i+1] <= sh[MW] ? sh[MW:1] : sh[MW-1:0];
				frac_s[i+1] <= {frac_s[i][FB-2:0], sh[MW]};
				exp_s[i+1]  <= exp_s[i];
			end
		end
	end

	assign log_val = {exp_s[FB], frac_s[FB]};
endmodule

>>> tb/tb.sv
// Self-checking testbench for the thermistor beta-equation temperature block.
module tb;
	localparam int LN2_C = 744261118;
	localparam int MAX_CYCLES = 2000000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [15:0] s_axis_tdata = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [23:0] m_axis_tdata;
	logic m_axis_tuser;
	logic cfg_wr_en = 1'b0;
	logic [tbt_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [tbt_pkg::CFG_W-1:0] cfg_wdata = '0;

	thermistor_beta_temperature uut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
		.cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Predictor copy of the register set.
	logic [19:0] series_ohm;
	logic [23:0] r25_ohm;
	logic [15:0] beta_k;
	logic [15:0] t25_ck;
	logic [11:0] full_scale;

	typedef struct packed {
		logic [18:0] temp;
		logic flag;
	} temp_word_t;

	logic [11:0] sample_queue[$];
	temp_word_t temp_expected[$];
	int failures = 0;
	int cycles = 0;
	bit idle_enable = 1'b1;
	int send_gap = 0;
	int recv_gap = 0;

	function automatic logic [63:0] log2_fixed(input logic [63:0] v);
		int k;
		logic [63:0] m;
		logic [127:0] sq;
		logic [63:0] frac;
		k = 0;
		frac = '0;
		while (k < 63 && (v >> (k + 1)) != 0)
			k++;
		if (k <= 31)
			m = v << (31 - k);
		else
			m = v >> (k - 31);
		for (int i = 0; i < 24; i++) begin
			sq = 128'(m) * 128'(m);
			m = sq[94:31];
			frac = frac << 1;
			if (m >= 64'h1_0000_0000) begin
				m = m >> 1;
				frac[0] = 1'b1;
			end
		end
		return (64'(k) << 24) | frac;
	endfunction

	function automatic temp_word_t beta_temperature(input logic [11:0] sample);
		logic [63:0] s, r0, b, t0, n, d, ln_n, ln_d, mag, lnmag, num, tck;
		logic signed [63:0] lnq, den;
		temp_word_t w;
		s = 64'(sample);
		r0 = r25_ohm != 0 ? 64'(r25_ohm) : 64'd1;
		b = beta_k != 0 ? 64'(beta_k) : 64'd1;
		t0 = t25_ck != 0 ? 64'(t25_ck) : 64'd1;
		if (s > 64'(full_scale))
			s = 64'(full_scale);
		n = 64'(series_ohm) * s;
		if (n == 0) begin
			w.temp = -19'sd27315;
			w.flag = 1'b1;
			return w;
		end
		d = r0 * (64'(full_scale) - s + 64'd1);
		ln_n = log2_fixed(n);
		ln_d = log2_fixed(d);
		mag = ln_n < ln_d ? ln_d - ln_n : ln_n - ln_d;
		lnmag = (mag * 64'(LN2_C) + (64'd1 << 29)) >> 30;
		lnq = ln_n < ln_d ? -$signed(lnmag) : $signed(lnmag);
		den = lnq * $signed(t0) + $signed((64'd100 * b) << 24);
		if (den == 0) begin
			w.temp = 19'd262143;
			w.flag = 1'b1;
		end else if (den < 0) begin
			w.temp = -19'sd27315;
			w.flag = 1'b1;
		end else begin
			num = (64'd100 * t0 * b) << 24;
			tck = (num + ($unsigned(den) >> 1)) / $unsigned(den);
			if (tck > 64'd289458) begin
				w.temp = 19'd262143;
				w.flag = 1'b1;
			end else begin
				w.temp = 19'(tck - 64'd27315);
				w.flag = 1'b0;
			end
		end
		return w;
	endfunction

	// Driver: offers queued samples, with random idle bursts between words.
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready) begin
				temp_expected.push_back(beta_temperature(s_axis_tdata[11:0]));
				void'(sample_queue.pop_front());
			end
			// A word on offer stays unchanged until it is taken.
			if (!s_axis_tvalid || s_axis_tready) begin
				if (send_gap > 0) begin
					send_gap <= send_gap - 1;
					s_axis_tvalid <= 1'b0;
				end else if (idle_enable && $urandom_range(0, 15) == 0) begin
					send_gap <= $urandom_range(1, 9) - 1;
					s_axis_tvalid <= 1'b0;
				end else if (sample_queue.size() > 0) begin
					s_axis_tvalid <= 1'b1;
					s_axis_tdata <= {4'b0, sample_queue[0]};
				end else
					s_axis_tvalid <= 1'b0;
			end
		end
	end

	// Monitor: checks each result word against the oldest prediction.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (temp_expected.size() == 0) begin
					$display("%0t: unexpected word temp=%0d flag=%0b", $time,
						$signed(m_axis_tdata[18:0]), m_axis_tuser);
					failures <= failures + 1;
				end else begin
					if (m_axis_tdata != {5'b0, temp_expected[0].temp}) begin
						$display("%0t: temp expected %0d actual %0d", $time,
							$signed(temp_expected[0].temp), $signed(m_axis_tdata[18:0]));
					end
					if (m_axis_tuser != temp_expected[0].flag) begin
						$display("%0t: out_of_range expected %0b actual %0b", $time,
							temp_expected[0].flag, m_axis_tuser);
					end
					if (m_axis_tdata != {5'b0, temp_expected[0].temp} ||
						m_axis_tuser != temp_expected[0].flag)
						failures <= failures + 1;
					void'(temp_expected.pop_front());
				end
			end
			if (recv_gap > 0) begin
				recv_gap <= recv_gap - 1;
				m_axis_tready <= 1'b0;
			end else if (idle_enable && $urandom_range(0, 15) == 0) begin
				recv_gap <= $urandom_range(1, 9) - 1;
				m_axis_tready <= 1'b0;
			end else
				m_axis_tready <= 1'b1;
		end
		if (cycles > MAX_CYCLES) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	task automatic write_reg(input tbt_pkg::cfg_idx_t idx, input logic [23:0] value);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		case (idx)
			tbt_pkg::CFG_SERIES: series_ohm = value[19:0];
			tbt_pkg::CFG_NOMINAL_R: r25_ohm = value;
			tbt_pkg::CFG_BETA: beta_k = value[15:0];
			tbt_pkg::CFG_NOMINAL_T: t25_ck = value[15:0];
			tbt_pkg::CFG_FULL_SCALE: full_scale = value[11:0];
			default: ;
		endcase
	endtask

	task automatic drain_pipeline;
		while (sample_queue.size() != 0 || temp_expected.size() != 0)
			@(posedge clk);
		repeat (70) @(posedge clk);
	endtask

	task automatic queue_samples(input int count);
		for (int i = 0; i < count; i++) begin
			case ($urandom_range(0, 5))
				0: sample_queue.push_back(12'($urandom_range(0, 15)));
				1: sample_queue.push_back(12'($urandom_range(4080, 4095)));
				default: sample_queue.push_back(12'($urandom));
			endcase
		end
	endtask

	initial begin
		series_ohm = 10000;
		r25_ohm = 100000;
		beta_k = 4390;
		t25_ck = 29815;
		full_scale = 4095;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// Directed samples at reset settings: zero, ones, mid, full scale.
		sample_queue.push_back(0);
		sample_queue.push_back(1);
		sample_queue.push_back(2);
		sample_queue.push_back(12'h555);
		sample_queue.push_back(12'haaa);
		sample_queue.push_back(2048);
		sample_queue.push_back(4094);
		sample_queue.push_back(4095);
		drain_pipeline();

		// Clamping above full scale, zero series, zero registers taken as one.
		write_reg(tbt_pkg::CFG_FULL_SCALE, 1000);
		sample_queue.push_back(999);
		sample_queue.push_back(1000);
		sample_queue.push_back(1001);
		sample_queue.push_back(4095);
		drain_pipeline();
		write_reg(tbt_pkg::CFG_SERIES, 0);
		write_reg(tbt_pkg::CFG_NOMINAL_R, 0);
		write_reg(tbt_pkg::CFG_BETA, 0);
		write_reg(tbt_pkg::CFG_NOMINAL_T, 0);
		sample_queue.push_back(5);
		sample_queue.push_back(4095);
		drain_pipeline();
		// Extremes: negative temperature and too-hot saturation.
		write_reg(tbt_pkg::CFG_SERIES, 20'hfffff);
		write_reg(tbt_pkg::CFG_NOMINAL_R, 1);
		write_reg(tbt_pkg::CFG_BETA, 1);
		write_reg(tbt_pkg::CFG_NOMINAL_T, 16'hffff);
		write_reg(tbt_pkg::CFG_FULL_SCALE, 1);
		sample_queue.push_back(1);
		sample_queue.push_back(0);
		drain_pipeline();
		write_reg(tbt_pkg::CFG_SERIES, 1);
		write_reg(tbt_pkg::CFG_NOMINAL_R, 24'hffffff);
		write_reg(tbt_pkg::CFG_BETA, 16'hffff);
		write_reg(tbt_pkg::CFG_FULL_SCALE, 4095);
		sample_queue.push_back(1);
		sample_queue.push_back(4095);
		drain_pipeline();

		// Random phases over random register sets; the first phase uses defaults.
		for (int p = 0; p < 8; p++) begin
			if (p == 0) begin
				write_reg(tbt_pkg::CFG_SERIES, 10000);
				write_reg(tbt_pkg::CFG_NOMINAL_R, 100000);
				write_reg(tbt_pkg::CFG_BETA, 4390);
				write_reg(tbt_pkg::CFG_NOMINAL_T, 29815);
			end else begin
				write_reg(tbt_pkg::CFG_SERIES, 24'($urandom_range(1, 20'hfffff)));
				write_reg(tbt_pkg::CFG_NOMINAL_R, 24'($urandom_range(1, 24'hffffff)));
				write_reg(tbt_pkg::CFG_BETA, 24'($urandom_range(1, 16'hffff)));
				write_reg(tbt_pkg::CFG_NOMINAL_T, 24'($urandom_range(1, 16'hffff)));
				write_reg(tbt_pkg::CFG_FULL_SCALE, 24'($urandom_range(1, 4095)));
			end
			if (p == 7)
				idle_enable = 1'b0;
			queue_samples(250);
			drain_pipeline();
		end

		if (failures == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end
endmodule

>>> sim.f
+incdir+rtl
rtl/tbt_pkg.sv
rtl/tbt_log2.sv
rtl/thermistor_beta_temperature.sv
tb/tb.sv
